// ===== hdl/bpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants, control word layout and microcode table of the bicubic
// patch evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

    // number formats
    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PARAM_BITS  = FRAC_BITS + 2;
    localparam int W_BITS      = FRAC_BITS + 1;
    localparam int SIDE        = 4;
    localparam int GRID_POINTS = SIDE * SIDE;
    localparam int IDX_BITS    = 4;
    localparam int SIDE_BITS   = 2;
    localparam int PROD_BITS   = COORD_BITS + W_BITS + 1;
    localparam int ACC_BITS    = PROD_BITS + IDX_BITS;
    localparam int POINT_BITS  = 3 * COORD_BITS;

    // stream payload sizes
    localparam int S_FIELD_BITS = IDX_BITS + 3 * COORD_BITS + 2 * PARAM_BITS;
    localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((3 * COORD_BITS + 7) / 8) * 8;

    localparam logic [W_BITS-1:0] ONE_FX  = W_BITS'(1) << FRAC_BITS;
    localparam logic [W_BITS-1:0] HALF_FX = W_BITS'(1) << (FRAC_BITS - 1);

    // operation codes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // weight multiplier operand codes
    localparam logic [3:0] OPD_ZERO   = 4'd0;
    localparam logic [3:0] OPD_T_U    = 4'd1;
    localparam logic [3:0] OPD_S_U    = 4'd2;
    localparam logic [3:0] OPD_T_V    = 4'd3;
    localparam logic [3:0] OPD_S_V    = 4'd4;
    localparam logic [3:0] OPD_TT     = 4'd5;
    localparam logic [3:0] OPD_SS     = 4'd6;
    localparam logic [3:0] OPD_TS     = 4'd7;
    localparam logic [3:0] OPD_BU_COL = 4'd8;
    localparam logic [3:0] OPD_BV_ROW = 4'd9;

    // weight multiplier destination codes
    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_TT   = 4'd1;
    localparam logic [3:0] DST_SS   = 4'd2;
    localparam logic [3:0] DST_TS   = 4'd3;
    localparam logic [3:0] DST_BU0  = 4'd4;
    localparam logic [3:0] DST_BU1  = 4'd5;
    localparam logic [3:0] DST_BU2  = 4'd6;
    localparam logic [3:0] DST_BU3  = 4'd7;
    localparam logic [3:0] DST_BV0  = 4'd8;
    localparam logic [3:0] DST_BV1  = 4'd9;
    localparam logic [3:0] DST_BV2  = 4'd10;
    localparam logic [3:0] DST_BV3  = 4'd11;
    localparam logic [3:0] DST_W    = 4'd12;

    // jump conditions
    localparam logic [1:0] COND_NONE     = 2'd0;
    localparam logic [1:0] COND_NO_START = 2'd1;
    localparam logic [1:0] COND_LOOP     = 2'd2;
    localparam logic [1:0] COND_OUT_BUSY = 2'd3;

    // program steps
    localparam int STEP_BITS = 5;
    localparam logic [STEP_BITS-1:0] STEP_IDLE  = 5'd0;
    localparam logic [STEP_BITS-1:0] STEP_MAC   = 5'd15;
    localparam logic [STEP_BITS-1:0] STEP_DRAIN = 5'd16;
    localparam logic [STEP_BITS-1:0] STEP_OUT   = 5'd17;

    typedef struct packed {
        logic [3:0]           op_a;
        logic [3:0]           op_b;
        logic [3:0]           dst;
        logic                 triple;
        logic                 clr_acc;
        logic                 issue;
        logic                 out_load;
        logic                 ret;
        logic [1:0]           cond;
        logic [STEP_BITS-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t          word;
        logic [IDX_BITS-1:0] point;
        logic                idle;
    } seq_ctrl_t;

    function automatic ctrl_word_t mk_word(
        input logic [3:0]           op_a,
        input logic [3:0]           op_b,
        input logic [3:0]           dst,
        input logic                 triple,
        input logic                 clr_acc,
        input logic                 issue,
        input logic                 out_load,
        input logic                 ret,
        input logic [1:0]           cond,
        input logic [STEP_BITS-1:0] target
    );
        ctrl_word_t w;
        w.op_a     = op_a;
        w.op_b     = op_b;
        w.dst      = dst;
        w.triple   = triple;
        w.clr_acc  = clr_acc;
        w.issue    = issue;
        w.out_load = out_load;
        w.ret      = ret;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    // microcode: idle wait, bernstein weights of u, then v, then the point loop, drain and output
    function automatic ctrl_word_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ctrl_word_t w;
        unique case (step)
            5'd0:  w = mk_word(OPD_ZERO, OPD_ZERO, DST_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NO_START, STEP_IDLE);
            5'd1:  w = mk_word(OPD_T_U, OPD_T_U, DST_TT, 1'b0, 1'b1, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd2:  w = mk_word(OPD_S_U, OPD_S_U, DST_SS, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd3:  w = mk_word(OPD_T_U, OPD_S_U, DST_TS, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd4:  w = mk_word(OPD_SS, OPD_S_U, DST_BU0, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd5:  w = mk_word(OPD_TS, OPD_S_U, DST_BU1, 1'b1, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd6:  w = mk_word(OPD_TS, OPD_T_U, DST_BU2, 1'b1, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd7:  w = mk_word(OPD_TT, OPD_T_U, DST_BU3, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd8:  w = mk_word(OPD_T_V, OPD_T_V, DST_TT, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd9:  w = mk_word(OPD_S_V, OPD_S_V, DST_SS, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd10: w = mk_word(OPD_T_V, OPD_S_V, DST_TS, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd11: w = mk_word(OPD_SS, OPD_S_V, DST_BV0, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd12: w = mk_word(OPD_TS, OPD_S_V, DST_BV1, 1'b1, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd13: w = mk_word(OPD_TS, OPD_T_V, DST_BV2, 1'b1, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd14: w = mk_word(OPD_TT, OPD_T_V, DST_BV3, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd15: w = mk_word(OPD_BU_COL, OPD_BV_ROW, DST_W, 1'b0, 1'b0, 1'b1, 1'b0,
                               1'b0, COND_LOOP, STEP_MAC);
            5'd16: w = mk_word(OPD_ZERO, OPD_ZERO, DST_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, COND_NONE, STEP_IDLE);
            5'd17: w = mk_word(OPD_ZERO, OPD_ZERO, DST_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                               1'b1, COND_OUT_BUSY, STEP_OUT);
            default: w = mk_word(OPD_ZERO, OPD_ZERO, DST_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                                 1'b1, COND_NONE, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/bicubic_patch_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_patch_evaluator
// Evaluates one vertex of a bicubic Bezier patch from a 4x4 grid of Q16.16
// control points, driven by a microcoded sequencer.
//
//   channel  dir  fields
//   s_       in   tuser: operation; tdata: point_index, point_x/y/z,
//                 param_u, param_v
//   m_       out  tdata: vertex_x, vertex_y, vertex_z
//
// A load transaction is written into the grid memory when it is accepted.
// An evaluate transaction runs 14 steps of the shared weight multiplier,
// the point loop over the 16 control points (one point per cycle through
// the three coordinate lanes), one drain and one output step.
// The result sits in an output register; while it waits, loads and a new
// evaluate are still taken, and the sequencer holds in its last step only
// if a second result is ready before the first was taken.
// Reset clears the sequencer and the output valid; grid contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module bicubic_patch_evaluator
    import bpe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_index[3:0], point_x[35:4], point_y[67:36], point_z[99:68],
    // param_u[117:100], param_v[135:118]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // vertex_x[31:0], vertex_y[63:32], vertex_z[95:64]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int X_LSB = IDX_BITS;
    localparam int U_LSB = IDX_BITS + POINT_BITS;
    localparam int V_LSB = U_LSB + PARAM_BITS;

    seq_ctrl_t             ctrl;
    logic                  s_fire;
    logic                  start;
    logic                  wr_en;
    logic                  out_busy;
    logic                  out_load;
    logic [W_BITS-1:0]     weight;
    logic [POINT_BITS-1:0] vertex;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    // input transaction decode
    assign s_tready = ctrl.idle;
    assign s_fire   = s_tvalid && s_tready;
    assign start    = s_fire && (s_tuser[0] == OP_EVAL);
    assign wr_en    = s_fire && (s_tuser[0] == OP_LOAD);

    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = ctrl.word.out_load && !out_busy;

    bpe_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    bpe_weight_unit u_weight (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .start   (start),
        .param_u (s_tdata[U_LSB +: PARAM_BITS]),
        .param_v (s_tdata[V_LSB +: PARAM_BITS]),
        .weight  (weight)
    );

    bpe_point_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .wr_en    (wr_en),
        .wr_index (s_tdata[IDX_BITS-1:0]),
        .wr_point (s_tdata[X_LSB +: POINT_BITS]),
        .weight   (weight),
        .vertex   (vertex)
    );

    // output register
    always_comb begin
        priority if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'(vertex);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // an evaluate transaction occupies the sequencer
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_tready)
        else $error("input ready right after evaluate transaction");

    // a result only appears from the output step
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(ctrl.word.out_load))
        else $error("result valid without output step");
`endif

endmodule

// ===== hdl/bpe_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_sequencer
// Step counter over the microcode table with conditional jumps and the
// control point loop counter.
// ----------------------------------------------------------------------------
module bpe_sequencer
    import bpe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  logic      out_busy,
    output seq_ctrl_t ctrl
);

    logic [STEP_BITS-1:0] pc_reg;
    logic [STEP_BITS-1:0] pc_next;
    logic [IDX_BITS-1:0]  point_reg;
    logic [IDX_BITS-1:0]  point_next;
    ctrl_word_t           word;
    logic                 jump;

    // control word lookup
    assign word = ucode_rom(pc_reg);

    // jump condition
    always_comb begin
        unique case (word.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_START: jump = !start;
            COND_LOOP:     jump = (point_reg != {IDX_BITS{1'b1}});
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        priority if (jump) begin
            pc_next = word.target;
        end else if (word.ret) begin
            pc_next = STEP_IDLE;
        end else begin
            pc_next = STEP_BITS'(pc_reg + 1'b1);
        end
    end

    // point loop counter wraps back to zero after the last point
    assign point_next = word.issue ? IDX_BITS'(point_reg + 1'b1) : point_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= STEP_IDLE;
            point_reg <= '0;
        end else begin
            pc_reg    <= pc_next;
            point_reg <= point_next;
        end
    end

    assign ctrl.word  = word;
    assign ctrl.point = point_reg;
    assign ctrl.idle  = (pc_reg == STEP_IDLE);

`ifndef SYNTHESIS
    // the loop always leaves through the drain step
    a_loop_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (word.issue && point_reg == {IDX_BITS{1'b1}}) |=> (pc_reg == STEP_DRAIN))
        else $error("point loop did not exit to drain step");

    // a new evaluation starts with the loop counter at zero
    a_idle_point: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_IDLE) |-> (point_reg == '0))
        else $error("loop counter not zero while idle");
`endif

endmodule

// ===== hdl/bpe_weight_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_weight_unit
// Parameter clamp, scalar registers and the shared rounding multiplier that
// forms the Bernstein weights and the per-point product weights.
// ----------------------------------------------------------------------------
module bpe_weight_unit
    import bpe_pkg::*;
(
    input  logic                  aclk,
    input  seq_ctrl_t             ctrl,
    input  logic                  start,
    input  logic [PARAM_BITS-1:0] param_u,
    input  logic [PARAM_BITS-1:0] param_v,
    output logic [W_BITS-1:0]     weight
);

    logic [W_BITS-1:0] t_u_reg, s_u_reg, t_v_reg, s_v_reg;
    logic [W_BITS-1:0] tt_reg, ss_reg, ts_reg;
    logic [W_BITS-1:0] bu_reg [SIDE];
    logic [W_BITS-1:0] bv_reg [SIDE];
    logic [W_BITS-1:0] w_reg;
    logic [W_BITS-1:0] t_u_next, t_v_next;
    logic [W_BITS-1:0] opa, opb;
    logic [2*W_BITS-1:0] prod;
    logic [2*W_BITS:0]   prod_rnd;
    logic [W_BITS-1:0]   rnd;
    logic [W_BITS-1:0]   res;

    // clamp to the range zero to one
    function automatic logic [W_BITS-1:0] clamp(input logic [PARAM_BITS-1:0] p);
        logic [W_BITS-1:0] r;
        if (p[PARAM_BITS-1]) begin
            r = '0;
        end else if ($signed(p) > $signed(PARAM_BITS'(ONE_FX))) begin
            r = ONE_FX;
        end else begin
            r = p[W_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [W_BITS-1:0] pick(
        input logic [3:0]          code,
        input logic [IDX_BITS-1:0] point
    );
        logic [W_BITS-1:0] v;
        unique case (code)
            OPD_T_U:    v = t_u_reg;
            OPD_S_U:    v = s_u_reg;
            OPD_T_V:    v = t_v_reg;
            OPD_S_V:    v = s_v_reg;
            OPD_TT:     v = tt_reg;
            OPD_SS:     v = ss_reg;
            OPD_TS:     v = ts_reg;
            OPD_BU_COL: v = bu_reg[point[SIDE_BITS-1:0]];
            OPD_BV_ROW: v = bv_reg[point[IDX_BITS-1:SIDE_BITS]];
            default:    v = '0;
        endcase
        return v;
    endfunction

    assign t_u_next = clamp(param_u);
    assign t_v_next = clamp(param_v);

    // operand select, follows the scalar registers as well as the control word
    always_comb begin
        opa = pick(ctrl.word.op_a, ctrl.point);
        opb = pick(ctrl.word.op_b, ctrl.point);
    end

    // rounding multiply, with the optional factor of three
    assign prod     = opa * opb;
    assign prod_rnd = {1'b0, prod} + (2*W_BITS+1)'(HALF_FX);
    assign rnd      = prod_rnd[FRAC_BITS +: W_BITS];
    assign res      = ctrl.word.triple ? W_BITS'({rnd, 1'b0} + {1'b0, rnd}) : rnd;

    // parameters latched when an evaluate transaction is taken
    always_ff @(posedge aclk) begin
        if (start) begin
            t_u_reg <= t_u_next;
            s_u_reg <= W_BITS'(ONE_FX - t_u_next);
            t_v_reg <= t_v_next;
            s_v_reg <= W_BITS'(ONE_FX - t_v_next);
        end
    end

    // result write back
    always_ff @(posedge aclk) begin
        unique case (ctrl.word.dst)
            DST_TT:  tt_reg    <= res;
            DST_SS:  ss_reg    <= res;
            DST_TS:  ts_reg    <= res;
            DST_BU0: bu_reg[0] <= res;
            DST_BU1: bu_reg[1] <= res;
            DST_BU2: bu_reg[2] <= res;
            DST_BU3: bu_reg[3] <= res;
            DST_BV0: bv_reg[0] <= res;
            DST_BV1: bv_reg[1] <= res;
            DST_BV2: bv_reg[2] <= res;
            DST_BV3: bv_reg[3] <= res;
            DST_W:   w_reg     <= res;
            default: ;
        endcase
    end

    assign weight = w_reg;

endmodule

// ===== hdl/bpe_point_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_point_mac
// Control grid memory and three multiply-accumulate lanes, one per
// coordinate, with final rounding and saturation.
// ----------------------------------------------------------------------------
module bpe_point_mac
    import bpe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  seq_ctrl_t             ctrl,
    input  logic                  wr_en,
    input  logic [IDX_BITS-1:0]   wr_index,
    input  logic [POINT_BITS-1:0] wr_point,
    input  logic [W_BITS-1:0]     weight,
    output logic [POINT_BITS-1:0] vertex
);

    localparam int HI_BITS = ACC_BITS - (COORD_BITS + FRAC_BITS - 1);

    logic [POINT_BITS-1:0] grid_mem [GRID_POINTS];
    logic [POINT_BITS-1:0] rd_reg;
    logic                  mac_v_reg;
    logic signed [ACC_BITS-1:0] acc_reg  [3];
    logic signed [ACC_BITS-1:0] acc_next [3];

    // round half up, then clip to the coordinate range
    function automatic logic [COORD_BITS-1:0] sat_round(input logic [ACC_BITS-1:0] a);
        logic [ACC_BITS-1:0] s;
        logic [HI_BITS-1:0]  hi;
        logic [COORD_BITS-1:0] r;
        s  = a + ACC_BITS'(HALF_FX);
        hi = s[ACC_BITS-1 -: HI_BITS];
        if (hi == '0 || hi == '1) begin
            r = s[FRAC_BITS +: COORD_BITS];
        end else if (hi[HI_BITS-1]) begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // grid memory, one point per entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_index] <= wr_point;
        end
        rd_reg <= grid_mem[ctrl.point];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_v_reg <= 1'b0;
        end else begin
            mac_v_reg <= ctrl.word.issue;
        end
    end

    // one lane per coordinate
    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [PROD_BITS-1:0] prod;

        assign prod = $signed(rd_reg[k*COORD_BITS +: COORD_BITS])
                    * $signed({1'b0, weight});

        always_comb begin
            acc_next[k] = acc_reg[k]
                        + {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
        end

        always_ff @(posedge aclk) begin
            if (ctrl.word.clr_acc) begin
                acc_reg[k] <= '0;
            end else if (mac_v_reg) begin
                acc_reg[k] <= acc_next[k];
            end
        end

        assign vertex[k*COORD_BITS +: COORD_BITS] = sat_round(acc_reg[k]);
    end

endmodule

// ===== test/tb_bicubic_patch_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bicubic_patch_evaluator
// Self-checking bench for the bicubic patch evaluator. A clocked driver feeds
// load and evaluate transactions from a backlog queue. It keeps its own copy
// of the control grid and predicts each vertex with the Bernstein weights in
// Q16.16, with rounding and saturation. A clocked monitor checks every output
// transaction against the oldest predicted vertex. The run goes through a
// directed part and then random phases with different amounts of sender idling
// and receiver stalling. One phase has a long receiver hold-off that fills
// up the block.
// ----------------------------------------------------------------------------
module tb_bicubic_patch_evaluator;
    import bpe_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 206;

    localparam longint UNIT      = longint'(1) << FRAC_BITS;
    localparam longint HALF_UNIT = longint'(1) << (FRAC_BITS - 1);
    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PARAM_BITS-1:0] param_t;
    typedef logic [SIDE-1:0][31:0]        basis_t;

    typedef struct packed {
        logic                op;
        logic [IDX_BITS-1:0] index;
        coord_t              x;
        coord_t              y;
        coord_t              z;
        param_t              u;
        param_t              v;
    } patch_item_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // point_index, point_x, point_y, point_z, param_u, param_v
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // operation
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // vertex_x, vertex_y, vertex_z
    logic [M_TDATA_W-1:0] m_tdata;

    patch_item_t item_backlog[$];
    vertex_t     predicted_vertices[$];
    patch_item_t cur_item;

    coord_t grid_x[GRID_POINTS];
    coord_t grid_y[GRID_POINTS];
    coord_t grid_z[GRID_POINTS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    bit hold_seen      = 1'b0;
    int hold_left      = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    bicubic_patch_evaluator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // round to nearest at the fraction point, floor on the shift
    function automatic longint round_fx(input longint a);
        return (a + HALF_UNIT) >>> FRAC_BITS;
    endfunction

    // cubic bernstein weights of a clamped parameter
    function automatic basis_t bernstein(input param_t p);
        longint t;
        longint s;
        longint tt;
        longint ss;
        longint ts;
        basis_t b;
        t = longint'(p);
        if (t < 0) begin
            t = 0;
        end else if (t > UNIT) begin
            t = UNIT;
        end
        s    = UNIT - t;
        tt   = round_fx(t * t);
        ss   = round_fx(s * s);
        ts   = round_fx(t * s);
        b[0] = 32'(round_fx(ss * s));
        b[1] = 32'(3 * round_fx(ts * s));
        b[2] = 32'(3 * round_fx(ts * t));
        b[3] = 32'(round_fx(tt * t));
        return b;
    endfunction

    function automatic coord_t saturate(input longint acc);
        longint r;
        r = round_fx(acc);
        if (r > COORD_MAX) begin
            r = COORD_MAX;
        end else if (r < COORD_MIN) begin
            r = COORD_MIN;
        end
        return coord_t'(r);
    endfunction

    // weighted sum of the whole grid at (u, v)
    function automatic vertex_t eval_vertex(input param_t u, input param_t v);
        basis_t  bu;
        basis_t  bv;
        longint  w;
        longint  acc_x;
        longint  acc_y;
        longint  acc_z;
        int      r;
        int      c;
        vertex_t res;
        bu    = bernstein(u);
        bv    = bernstein(v);
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        for (r = 0; r < SIDE; r++) begin
            for (c = 0; c < SIDE; c++) begin
                w = round_fx(longint'(bu[c]) * longint'(bv[r]));
                acc_x += longint'(grid_x[r * SIDE + c]) * w;
                acc_y += longint'(grid_y[r * SIDE + c]) * w;
                acc_z += longint'(grid_z[r * SIDE + c]) * w;
            end
        end
        res.x = saturate(acc_x);
        res.y = saturate(acc_y);
        res.z = saturate(acc_z);
        return res;
    endfunction

    // an accepted transaction updates the grid or owes a vertex
    task automatic apply_item(input patch_item_t it);
        if (it.op == OP_LOAD) begin
            grid_x[it.index] = it.x;
            grid_y[it.index] = it.y;
            grid_z[it.index] = it.z;
        end else begin
            predicted_vertices.push_back(eval_vertex(it.u, it.v));
        end
    endtask

    function automatic patch_item_t make_item(input logic op, input int index,
                                              input coord_t x, input coord_t y,
                                              input coord_t z, input param_t u,
                                              input param_t v);
        patch_item_t it;
        it.op    = op;
        it.index = IDX_BITS'(index);
        it.x     = x;
        it.y     = y;
        it.z     = z;
        it.u     = u;
        it.v     = v;
        return it;
    endfunction

    function automatic coord_t random_coord();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0: begin
                case ($urandom_range(3))
                    0: return coord_t'(COORD_MAX);
                    1: return coord_t'(COORD_MIN);
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return coord_t'(int'($urandom_range(2097151)) - 1048576);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic param_t random_param();
        case ($urandom_range(10))
            0: return '0;
            1: return param_t'(UNIT);
            2: return param_t'(-int'($urandom_range(131072, 1)));
            3: return param_t'($urandom_range(131071, 65537));
            10: return param_t'($urandom);
            default: return param_t'($urandom_range(65536));
        endcase
    endfunction

    // mostly evaluations, with fresh loads mixed in; ignored fields stay random
    function automatic patch_item_t random_item();
        patch_item_t it;
        it.op    = ($urandom_range(99) < 55) ? OP_EVAL : OP_LOAD;
        it.index = IDX_BITS'($urandom);
        it.x     = coord_t'($urandom);
        it.y     = coord_t'($urandom);
        it.z     = coord_t'($urandom);
        it.u     = param_t'($urandom);
        it.v     = param_t'($urandom);
        if (it.op == OP_LOAD) begin
            it.x = random_coord();
            it.y = random_coord();
            it.z = random_coord();
        end else begin
            it.u = random_param();
            it.v = random_param();
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what,
                 got, want);
        fail_count++;
    endtask

    // driver: offer the next pending transaction, hold it until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(cur_item);
            end
            if (!s_tvalid || s_tready) begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = item_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cur_item.v, cur_item.u, cur_item.z,
                                            cur_item.y, cur_item.x, cur_item.index});
                    s_tuser  <= cur_item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: compare each vertex transaction with the oldest prediction
    always @(posedge aclk) begin
        vertex_t want;
        vertex_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[COORD_BITS-1:0];
            got.y = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.z = m_tdata[3*COORD_BITS-1:2*COORD_BITS];
            if (predicted_vertices.size() == 0) begin
                report_mismatch("vertex with none pending", longint'(got.x), 0);
            end else begin
                want = predicted_vertices.pop_front();
                if (got.x !== want.x) report_mismatch("vertex_x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("vertex_y", got.y, want.y);
                if (got.z !== want.z) report_mismatch("vertex_z", got.z, want.z);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (item_backlog.size() != 0 || s_tvalid || predicted_vertices.size() != 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
        int n;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            item_backlog.push_back(random_item());
        end
        if (with_hold) begin
            hold_req = ~hold_req;
        end
        wait_idle();
    endtask

    // stimulus sequence
    initial begin
        int i;
        coord_t zc;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // fill the whole grid first: x at max, y at min, z varied
        for (i = 0; i < GRID_POINTS; i++) begin
            case (i % 4)
                0: zc = '0;
                1: zc = '1;
                2: zc = coord_t'($urandom);
                default: zc = coord_t'(i * 65536);
            endcase
            item_backlog.push_back(make_item(OP_LOAD, i, coord_t'(COORD_MAX),
                                             coord_t'(COORD_MIN), zc,
                                             param_t'($urandom), param_t'($urandom)));
        end
        // corners, clamping at both ends and the patch center
        item_backlog.push_back(make_item(OP_EVAL, 0, '0, '0, '0, '0, '0));
        item_backlog.push_back(make_item(OP_EVAL, 15, '1, '1, '1, param_t'(UNIT),
                                         param_t'(UNIT)));
        item_backlog.push_back(make_item(OP_EVAL, 5, '0, '0, '0, '0, param_t'(UNIT)));
        item_backlog.push_back(make_item(OP_EVAL, 10, '0, '0, '0, param_t'(UNIT), '0));
        item_backlog.push_back(make_item(OP_EVAL, 3, '0, '0, '0,
                                         param_t'(-131072), param_t'(131071)));
        item_backlog.push_back(make_item(OP_EVAL, 12, '0, '0, '0,
                                         param_t'(UNIT / 2), param_t'(UNIT / 2)));
        item_backlog.push_back(make_item(OP_EVAL, 7, '0, '0, '0,
                                         param_t'(131071), param_t'(-1)));
        wait_idle();

        run_phase(0, 0, 1'b0);
        run_phase(74, 0, 1'b0);
        run_phase(0, 74, 1'b0);
        run_phase(14, 14, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && predicted_vertices.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bpe_pkg.sv
hdl/bpe_sequencer.sv
hdl/bpe_weight_unit.sv
hdl/bpe_point_mac.sv
hdl/bicubic_patch_evaluator.sv
test/tb_bicubic_patch_evaluator.sv
